// ===== sv/swtfs_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// swtfs_pkg: shared types and constants
// Sequencer states, register indexes and result width for the sliding
// window x-sum block.
// ---------------------------------------------------------------------------
package swtfs_pkg;

   // register indexes (byte address / 4)
   localparam logic REG_WINDOW_LENGTH = 1'b0;
   localparam logic REG_TOP_COUNT     = 1'b1;

   localparam int SUM_W = 16;

   // sequencer states, one-hot
   typedef enum logic [10:0] {
      S_CLEAR    = 11'b000_0000_0001,
      S_IDLE     = 11'b000_0000_0010,
      S_EV_RING  = 11'b000_0000_0100,
      S_EV_CRD   = 11'b000_0000_1000,
      S_EV_CWR   = 11'b000_0001_0000,
      S_INS_RD   = 11'b000_0010_0000,
      S_INS_WR   = 11'b000_0100_0000,
      S_SCAN     = 11'b000_1000_0000,
      S_SCAN_END = 11'b001_0000_0000,
      S_SUM      = 11'b010_0000_0000,
      S_RESULT   = 11'b100_0000_0000
   } state_type;

endpackage

// ===== sv/sliding_window_top_frequent_sum.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sliding_window_top_frequent_sum: x-sum over a sliding window
// Keeps the last window_length values and a count per value, and after
// each request ranks the counts to give the sum over the top values.
// ---------------------------------------------------------------------------
// Usage:
//  Requests (req_sample_value, req_start_new) enter on req_valid/req_ready.
//  A request with req_start_new set empties the window and clears the
//  count table first. Once the window holds window_length values, each
//  request gives one result on rsp_valid/rsp_ready (rsp_x_sum); while it
//  fills, none.
//  Steps: after acceptance, a ring read, a count read and a count write per
//  evicted value, then a ring write with a count read and a count write for
//  the insert; when a result is due, a scan over the count memory (one read
//  per cycle, at most one insert into the sorted top list), a sum through
//  one multiplier and the load of the output register follow. A request
//  with start_new first adds a clear sweep of the count memory.
//  req_ready is high only while the sequencer is idle.
//  Reset: registers go to 1, the window empties, and a clear sweep
//  zeroes the count memory before the first request.
//  A result waits in the output register while rsp_ready is low; the
//  next request is taken meanwhile and only stalls if it too has a result.
//  Configuration: APB-style, always ready; window_length at 0, top_count
//  at 4.
// ---------------------------------------------------------------------------
module sliding_window_top_frequent_sum #(
   parameter int VALUE_COUNT = 256,
   parameter int WINDOW_MAX  = 256,
   parameter int TOP_MAX     = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_sample_value,
   input  logic        req_start_new,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_x_sum,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int VW = $clog2(VALUE_COUNT);
   localparam int PW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int FW = $clog2(WINDOW_MAX + 1);
   localparam int CW = FW;
   localparam int UW = $clog2(TOP_MAX + 1);
   localparam int TW = (TOP_MAX > 1) ? $clog2(TOP_MAX) : 1;
   localparam int AW = CW + VW + 7;

   swtfs_pkg::state_type state_ff, state_in;

   // configuration registers
   logic [8:0] window_length_ff;
   logic [4:0] top_count_ff;
   logic       cfg_we;

   assign pready = 1'b1;
   assign cfg_we = psel & penable & pwrite;
   assign prdata = (paddr[2] == swtfs_pkg::REG_TOP_COUNT) ? {27'b0, top_count_ff}
                                                          : {23'b0, window_length_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= 9'd1;
         top_count_ff     <= 5'd1;
      end else if (cfg_we) begin
         if (paddr[2] == swtfs_pkg::REG_TOP_COUNT) top_count_ff <= pwdata[4:0];
         else window_length_ff <= pwdata[8:0];
      end
   end

   // latched request and its limits
   logic [VW-1:0] val_ff, val_in;
   logic [FW-1:0] len_ff, len_in;
   logic [UW-1:0] lim_ff, lim_in;
   logic          clr_ins_ff, clr_ins_in;

   always_comb begin
      if (32'(req_sample_value) >= VALUE_COUNT) val_in = VW'(VALUE_COUNT - 1);
      else val_in = VW'(req_sample_value);
      if (window_length_ff == 9'd0) len_in = FW'(1);
      else if (32'(window_length_ff) > WINDOW_MAX) len_in = FW'(WINDOW_MAX);
      else len_in = FW'(window_length_ff);
      if (32'(top_count_ff) > TOP_MAX) lim_in = UW'(TOP_MAX);
      else lim_in = UW'(top_count_ff);
   end

   // window position
   logic [FW-1:0] fill_ff, fill_in;
   logic [PW-1:0] wp_ff, wp_in;
   logic [FW:0]   wpx, fillx, old_idx;

   assign wpx     = (FW + 1)'(wp_ff);
   assign fillx   = (FW + 1)'(fill_ff);
   assign old_idx = (wpx >= fillx) ? (wpx - fillx)
                                   : (wpx + (FW + 1)'(WINDOW_MAX) - fillx);

   // window ring memory
   logic [VW-1:0] ring_mem [WINDOW_MAX];
   logic [VW-1:0] ring_rdata_ff;
   logic          ring_we;

   always_ff @(posedge clock) begin
      if (ring_we) ring_mem[wp_ff] <= val_ff;
      ring_rdata_ff <= ring_mem[old_idx[PW-1:0]];
   end

   // count memory
   logic [CW-1:0] cnt_mem [VALUE_COUNT];
   logic [CW-1:0] cnt_rdata_ff, cnt_wdata;
   logic [VW-1:0] cnt_raddr, cnt_waddr;
   logic          cnt_we;

   always_ff @(posedge clock) begin
      if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
      cnt_rdata_ff <= cnt_mem[cnt_raddr];
   end

   // sweep / scan address and scan pipe
   logic [VW-1:0] addr_ff, addr_in;
   logic          scan_pv_ff, scan_pv_in;
   logic [VW-1:0] scan_val_ff;

   // sorted top list
   logic [CW-1:0] best_cnt_ff [TOP_MAX];
   logic [VW-1:0] best_val_ff [TOP_MAX];
   logic [CW-1:0] best_cnt_in [TOP_MAX];
   logic [VW-1:0] best_val_in [TOP_MAX];
   logic [UW-1:0] used_ff, used_in;
   logic [TOP_MAX-1:0] gt;
   logic          ins;

   // sum unit
   logic [UW:0]      sidx_ff, sidx_in;
   logic [CW+VW-1:0] prod_ff;
   logic             pv_ff, pv_in;
   logic [AW-1:0]    acc_ff, acc_in;
   logic [TW-1:0]    sidx_t;

   assign sidx_t = sidx_ff[TW-1:0];

   // output register
   logic        rsp_valid_ff;
   logic [15:0] rsp_x_sum_ff;
   logic        rsp_load;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_x_sum = rsp_x_sum_ff;
   assign req_ready = (state_ff == swtfs_pkg::S_IDLE);

   // insertion compare bank: strictly greater entries stay above
   always_comb begin
      for (int i = 0; i < TOP_MAX; i++) begin
         gt[i] = (UW'(i) < used_ff) && (best_cnt_ff[i] > cnt_rdata_ff);
      end
      ins = scan_pv_ff && (cnt_rdata_ff != '0) && (lim_ff != '0)
            && !gt[TW'(lim_ff - UW'(1))];
      for (int i = 0; i < TOP_MAX; i++) begin
         best_cnt_in[i] = best_cnt_ff[i];
         best_val_in[i] = best_val_ff[i];
         if (ins && !gt[i]) begin
            if (i == 0 || gt[(i > 0) ? i - 1 : 0]) begin
               best_cnt_in[i] = cnt_rdata_ff;
               best_val_in[i] = scan_val_ff;
            end else begin
               best_cnt_in[i] = best_cnt_ff[(i > 0) ? i - 1 : 0];
               best_val_in[i] = best_val_ff[(i > 0) ? i - 1 : 0];
            end
         end
      end
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      fill_in    = fill_ff;
      wp_in      = wp_ff;
      addr_in    = addr_ff;
      clr_ins_in = clr_ins_ff;
      scan_pv_in = 1'b0;
      used_in    = used_ff;
      sidx_in    = sidx_ff;
      pv_in      = 1'b0;
      acc_in     = acc_ff;
      ring_we    = 1'b0;
      cnt_we     = 1'b0;
      cnt_waddr  = addr_ff;
      cnt_wdata  = '0;
      cnt_raddr  = addr_ff;
      rsp_load   = 1'b0;
      if (ins) used_in = (used_ff < lim_ff) ? used_ff + UW'(1) : used_ff;
      unique case (state_ff)
         swtfs_pkg::S_CLEAR: begin
            cnt_we  = 1'b1;
            addr_in = addr_ff + VW'(1);
            if (32'(addr_ff) == VALUE_COUNT - 1) begin
               addr_in  = '0;
               state_in = clr_ins_ff ? swtfs_pkg::S_INS_RD : swtfs_pkg::S_IDLE;
            end
         end
         swtfs_pkg::S_IDLE: begin
            if (req_valid) begin
               if (req_start_new) begin
                  fill_in    = '0;
                  wp_in      = '0;
                  addr_in    = '0;
                  clr_ins_in = 1'b1;
                  state_in   = swtfs_pkg::S_CLEAR;
               end else if (fill_ff != '0 && fill_ff >= len_in) begin
                  state_in = swtfs_pkg::S_EV_RING;
               end else begin
                  state_in = swtfs_pkg::S_INS_RD;
               end
            end
         end
         swtfs_pkg::S_EV_RING: state_in = swtfs_pkg::S_EV_CRD;
         swtfs_pkg::S_EV_CRD: begin
            cnt_raddr = ring_rdata_ff;
            state_in  = swtfs_pkg::S_EV_CWR;
         end
         swtfs_pkg::S_EV_CWR: begin
            cnt_waddr = ring_rdata_ff;
            cnt_wdata = cnt_rdata_ff - CW'(1);
            cnt_we    = (cnt_rdata_ff != '0);
            fill_in   = fill_ff - FW'(1);
            if (fill_in != '0 && fill_in >= len_ff) state_in = swtfs_pkg::S_EV_RING;
            else state_in = swtfs_pkg::S_INS_RD;
         end
         swtfs_pkg::S_INS_RD: begin
            ring_we   = 1'b1;
            cnt_raddr = val_ff;
            state_in  = swtfs_pkg::S_INS_WR;
         end
         swtfs_pkg::S_INS_WR: begin
            cnt_we    = 1'b1;
            cnt_waddr = val_ff;
            cnt_wdata = cnt_rdata_ff + CW'(1);
            fill_in   = fill_ff + FW'(1);
            wp_in     = (32'(wp_ff) == WINDOW_MAX - 1) ? '0 : wp_ff + PW'(1);
            if (fill_in == len_ff) begin
               addr_in  = '0;
               used_in  = '0;
               state_in = swtfs_pkg::S_SCAN;
            end else begin
               state_in = swtfs_pkg::S_IDLE;
            end
         end
         swtfs_pkg::S_SCAN: begin
            scan_pv_in = 1'b1;
            addr_in    = addr_ff + VW'(1);
            if (32'(addr_ff) == VALUE_COUNT - 1) begin
               addr_in  = '0;
               state_in = swtfs_pkg::S_SCAN_END;
            end
         end
         swtfs_pkg::S_SCAN_END: begin
            sidx_in  = '0;
            acc_in   = '0;
            state_in = swtfs_pkg::S_SUM;
         end
         swtfs_pkg::S_SUM: begin
            pv_in   = (sidx_ff < (UW + 1)'(used_ff));
            sidx_in = sidx_ff + (UW + 1)'(1);
            if (pv_ff) acc_in = acc_ff + AW'(prod_ff);
            if (sidx_ff == (UW + 1)'(used_ff) + (UW + 1)'(1)) begin
               pv_in    = 1'b0;
               state_in = swtfs_pkg::S_RESULT;
            end
         end
         swtfs_pkg::S_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = swtfs_pkg::S_IDLE;
            end
         end
         default: state_in = swtfs_pkg::S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= swtfs_pkg::S_CLEAR;
         fill_ff      <= '0;
         wp_ff        <= '0;
         addr_ff      <= '0;
         clr_ins_ff   <= 1'b0;
         scan_pv_ff   <= 1'b0;
         used_ff      <= '0;
         pv_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         fill_ff    <= fill_in;
         wp_ff      <= wp_in;
         addr_ff    <= addr_in;
         clr_ins_ff <= clr_ins_in;
         scan_pv_ff <= scan_pv_in;
         used_ff    <= used_in;
         pv_ff      <= pv_in;
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         val_ff <= val_in;
         len_ff <= len_in;
         lim_ff <= lim_in;
      end
      scan_val_ff <= addr_ff;
      sidx_ff     <= sidx_in;
      acc_ff      <= acc_in;
      prod_ff     <= best_cnt_ff[sidx_t] * best_val_ff[sidx_t];
      for (int i = 0; i < TOP_MAX; i++) begin
         best_cnt_ff[i] <= best_cnt_in[i];
         best_val_ff[i] <= best_val_in[i];
      end
      if (rsp_load) begin
         if (64'(acc_ff) > 64'd65535) rsp_x_sum_ff <= 16'hFFFF;
         else rsp_x_sum_ff <= 16'(acc_ff);
      end
   end

   // checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= WINDOW_MAX)
      else $error("fill level beyond window depth");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while sequencer busy");

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == swtfs_pkg::S_SUM) |-> (used_ff <= lim_ff))
      else $error("top list holds more than the limit");

   a_result_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == swtfs_pkg::S_RESULT) |-> (fill_ff == len_ff))
      else $error("result with window not full");

endmodule

// ===== tb/sv/tb_sliding_window_top_frequent_sum.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_sliding_window_top_frequent_sum: self-checking bench for the window x-sum
// Drives value requests with random gaps and result back-pressure. It
// reprogrammes window length and top count between phases, and checks every
// x-sum against an in-bench ranking of the running value counts.
// ---------------------------------------------------------------------------
module tb_sliding_window_top_frequent_sum;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int SETTLE_CYCLES  = 1400;   // worst request: evictions, clear, scan

   // running window state and pending x-sums
   class xsum_scoreboard;
      bit [8:0]  counts [256];
      bit [7:0]  ring [256];
      int        fill, wr_ptr;
      bit [8:0]  window_len;
      bit [4:0]  top_len;
      bit [15:0] sums_due [$];
      int        errors;

      function new();
         foreach (counts[i]) counts[i] = '0;
         fill = 0;
         wr_ptr = 0;
         window_len = 9'd1;
         top_len = 5'd1;
         errors = 0;
      endfunction

      function void set_reg(logic idx, logic [31:0] data);
         if (idx == swtfs_pkg::REG_WINDOW_LENGTH) window_len = data[8:0];
         else top_len = data[4:0];
      endfunction

      // pick the top values one at a time: highest count, larger value on ties
      function bit [15:0] ranked_sum();
         int     lim, best;
         bit     taken [256];
         longint acc;
         acc = 0;
         lim = (top_len > 16) ? 16 : top_len;
         foreach (taken[i]) taken[i] = 1'b0;
         for (int k = 0; k < lim; k++) begin
            best = -1;
            for (int v = 255; v >= 0; v--)
               if (counts[v] != 0 && !taken[v] && (best < 0 || counts[v] > counts[best]))
                  best = v;
            if (best < 0) break;
            taken[best] = 1'b1;
            acc += longint'(counts[best]) * best;
         end
         return (acc > 65535) ? 16'hFFFF : acc[15:0];
      endfunction

      function void note_request(bit [7:0] value, bit start_new);
         int len, idx;
         len = (window_len == 0) ? 1 : (window_len > 256) ? 256 : window_len;
         if (start_new) begin
            foreach (counts[i]) counts[i] = '0;
            fill = 0;
            wr_ptr = 0;
         end
         // shrink or slide: drop the oldest values until the new one fits
         while (fill > 0 && fill >= len) begin
            idx = (wr_ptr + 256 - fill) % 256;
            if (counts[ring[idx]] > 0) counts[ring[idx]]--;
            fill--;
         end
         ring[wr_ptr] = value;
         counts[value]++;
         wr_ptr = (wr_ptr + 1) % 256;
         fill++;
         if (fill == len) sums_due.push_back(ranked_sum());
      endfunction

      task report_mismatch(string msg);
         $display("MISMATCH @%0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_result(bit [15:0] x_sum);
         bit [15:0] want;
         if (sums_due.size() == 0) begin
            report_mismatch($sformatf("unexpected x_sum %0d", x_sum));
         end else begin
            want = sums_due.pop_front();
            if (x_sum !== want)
               report_mismatch($sformatf("x_sum %0d, expected %0d", x_sum, want));
         end
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid, req_ready;
   logic [7:0]  req_sample_value;
   logic        req_start_new;
   logic        rsp_valid, rsp_ready;
   logic [15:0] rsp_x_sum;
   logic        psel, penable, pwrite, pready;
   logic [2:0]  paddr;
   logic [31:0] pwdata, prdata;

   xsum_scoreboard sb;
   bit calm;            // no idling on either side
   int hold_stretch;    // one-off long receiver stall
   int idle_count;
   int random_items;

   sliding_window_top_frequent_sum dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_sample_value(req_sample_value), .req_start_new(req_start_new),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_x_sum(rsp_x_sum),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // register write, then read back
   task csr_write(logic idx, logic [31:0] data);
      logic [31:0] mask;
      mask = (idx == swtfs_pkg::REG_WINDOW_LENGTH) ? 32'h1FF : 32'h1F;
      @(negedge clock);
      psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
      paddr <= {idx, 2'b00}; pwdata <= data;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      sb.set_reg(idx, data);
      @(negedge clock);
      pwrite <= 1'b0; penable <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if ((prdata & mask) !== (data & mask))
         sb.report_mismatch($sformatf("reg %0d reads %0h, wrote %0h", idx, prdata, data));
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0;
   endtask

   // one request; entered and left at a falling edge
   task send_request(bit [7:0] value, bit start_new);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_sample_value <= value;
      req_start_new <= start_new;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      sb.note_request(value, start_new);
      @(negedge clock);
   endtask

   // wait for every x-sum, then let the block settle before reconfiguring
   task drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.sums_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   function bit [7:0] draw_value(bit narrow);
      case ($urandom_range(0, 9))
         0: return 8'd0;
         1: return 8'd255;
         default: return narrow ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255));
      endcase
   endfunction

   // result side: random stalls, occasionally a long one
   initial begin
      int gap;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_stretch > 0) begin
            gap = hold_stretch;
            hold_stretch = 0;
         end else begin
            gap = calm ? 0 : $urandom_range(0, 14);
         end
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   always @(posedge clock)
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_x_sum);

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable))
         idle_count <= 0;
      else
         idle_count <= idle_count + 1;
      if (idle_count >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // stimulus
   initial begin
      int n, wl, tc;
      bit narrow;
      sb = new();
      calm = 1'b0;
      hold_stretch = 0;
      idle_count = 0;
      random_items = 0;
      reset = 1'b1;
      req_valid = 1'b0; req_sample_value = '0; req_start_new = 1'b0;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // defaults: window of one, top one, value extremes
      send_request(8'd0, 1'b0);
      send_request(8'd255, 1'b0);
      send_request(8'd255, 1'b1);
      send_request(8'd0, 1'b1);
      drain();
      // ties: equal counts go to the larger value
      csr_write(swtfs_pkg::REG_WINDOW_LENGTH, 32'd4);
      csr_write(swtfs_pkg::REG_TOP_COUNT, 32'd2);
      send_request(8'd3, 1'b1);
      send_request(8'd9, 1'b0);
      send_request(8'd3, 1'b0);
      send_request(8'd9, 1'b0);
      send_request(8'd255, 1'b0);
      send_request(8'd1, 1'b0);
      drain();
      // zero window and zero top count
      csr_write(swtfs_pkg::REG_WINDOW_LENGTH, 32'd0);
      csr_write(swtfs_pkg::REG_TOP_COUNT, 32'd0);
      send_request(8'd200, 1'b0);
      send_request(8'd17, 1'b1);
      drain();
      // oversized settings saturate: full 256 window, top 16
      csr_write(swtfs_pkg::REG_WINDOW_LENGTH, 32'h1FF);
      csr_write(swtfs_pkg::REG_TOP_COUNT, 32'h1F);
      calm = 1'b1;
      for (int i = 0; i < 270; i++) send_request(draw_value(i[0]), i == 0);
      calm = 1'b0;
      drain();
      // shrink while running, then grow
      csr_write(swtfs_pkg::REG_WINDOW_LENGTH, 32'd3);
      csr_write(swtfs_pkg::REG_TOP_COUNT, 32'd16);
      for (int i = 0; i < 5; i++) send_request(draw_value(1'b1), 1'b0);
      drain();
      csr_write(swtfs_pkg::REG_WINDOW_LENGTH, 32'd20);
      csr_write(swtfs_pkg::REG_TOP_COUNT, 32'd5);
      for (int i = 0; i < 25; i++) send_request(draw_value(1'b0), 1'b0);
      drain();

      // random phases, mostly short windows
      for (int phase = 0; random_items < 120 || phase < 3; phase++) begin
         wl = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 511) : $urandom_range(1, 16);
         tc = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 16);
         if (wl > 40) wl = $urandom_range(17, 40);
         csr_write(swtfs_pkg::REG_WINDOW_LENGTH, wl);
         csr_write(swtfs_pkg::REG_TOP_COUNT, tc);
         calm = ($urandom_range(0, 3) == 0);
         narrow = $urandom_range(0, 1);
         // one phase: short window with a long receiver stall, block backs up
         if (phase == 2) begin
            csr_write(swtfs_pkg::REG_WINDOW_LENGTH, 32'd1);
            hold_stretch = 400;
         end
         n = $urandom_range(30, 60);
         for (int i = 0; i < n; i++) begin
            send_request(draw_value(narrow), $urandom_range(0, 24) == 0);
            random_items++;
         end
         drain();
      end
      calm = 1'b0;

      repeat (400) @(posedge clock);
      if (sb.sums_due.size() != 0)
         sb.report_mismatch($sformatf("%0d x-sums never arrived", sb.sums_due.size()));
      if (sb.errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/swtfs_pkg.sv
sv/sliding_window_top_frequent_sum.sv
tb/sv/tb_sliding_window_top_frequent_sum.sv
